@@ sv/pct_pkg.sv @@
// Shared constants, codes and state type for the parity count segment tree.
// Used by parity_count_segment_tree_core and tb_top; no dependencies.
`timescale 1ns / 1ps

package pct_pkg;

    // Default array size, element_count reset value and field widths
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int IDX_W            = 11;
    localparam int CNT_W            = 11;
    localparam int VAL_W            = 32;
    localparam logic [IDX_W-1:0] ECOUNT_RESET = 11'd1024;

    // Stream packing widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;

    // Item modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_EVEN  = 2'd1;
    localparam logic [1:0] MODE_ODD   = 2'd2;
    localparam logic [1:0] MODE_BAD   = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_LEAF,
        ST_UPD_WALK,
        ST_QUERY,
        ST_FINISH
    } pct_state_t;

endpackage

@@ sv/pct_node_ram.sv @@
// Tree node store: one write port, two read ports, registered read data.
// Depends on nothing outside; sized by parameters from the top level.
`timescale 1ns / 1ps

module pct_node_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports, registered
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ sv/parity_count_segment_tree_core.sv @@
// Top level of the parity count segment tree: sequencer, config register, output stage.
// Depends on pct_pkg and pct_node_ram.
`timescale 1ns / 1ps
//
//  channel   dir   handshake              payload
//  s_*       in    s_tvalid / s_tready    s_tdata, s_tuser (mode)
//  m_*       out   m_tvalid / m_tready    m_tdata (count), m_tuser (error)
//  cfg_*     in    cfg_valid / cfg_ready  cfg_data (element_count)
//
//  Updates walk a heap-ordered tree in one memory: leaf read, then one node read
//  and write-back per level up to the root. Writes that do not flip parity end
//  after the leaf read; queries read two nodes per tree level; error items skip
//  the tree. After reset a clearing pass zeroes all 2*MAX_ELEMENTS nodes of the
//  node store; no item is taken meanwhile, config writes are. A result waits in
//  the output register while the next item is taken; a stalled m_tready holds
//  only a finished one.

module parity_count_segment_tree_core
    import pct_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // first_index[10:0], last_index[21:11], new_value[53:22], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]           s_tuser,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // count[10:0], zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // error[0]
    output logic                 m_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [IDX_W-1:0]     cfg_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready
);

    localparam int NODES  = 2 * MAX_ELEMENTS;
    localparam int NW     = $clog2(NODES);
    localparam int LW     = NW + 1;
    localparam int CW     = $clog2(MAX_ELEMENTS + 1);
    localparam int MAXCAP = (MAX_ELEMENTS > 2047) ? 2047 : MAX_ELEMENTS;

    // Input fields
    logic [IDX_W-1:0] in_first;
    logic [IDX_W-1:0] in_last;
    logic             in_par;
    logic [1:0]       in_mode;

    assign in_first = s_tdata[10:0];
    assign in_last  = s_tdata[21:11];
    assign in_par   = s_tdata[22];
    assign in_mode  = s_tuser;

    // Registers
    pct_state_t       state_reg, state_next;
    logic [IDX_W-1:0] ecount_reg, ecount_next;
    logic [NW-1:0]    clr_reg, clr_next;
    logic [LW-1:0]    lo_reg, lo_next;
    logic [LW-1:0]    hi_reg, hi_next;
    logic             up_reg, up_next;
    logic             odd_mode_reg, odd_mode_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] acc_reg, acc_next;
    logic             pend_reg, pend_next;
    logic             take_a_reg, take_a_next;
    logic             take_b_reg, take_b_next;
    logic [CNT_W-1:0] res_count_reg, res_count_next;
    logic             res_err_reg, res_err_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;
    logic             out_err_reg, out_err_next;

    // Memory ports
    logic          mem_we;
    logic [NW-1:0] mem_waddr;
    logic [CW-1:0] mem_wdata;
    logic [NW-1:0] mem_raddr_a;
    logic [NW-1:0] mem_raddr_b;
    logic [CW-1:0] mem_rdata_a;
    logic [CW-1:0] mem_rdata_b;

    pct_node_ram #(
        .DEPTH (NODES),
        .AW    (NW),
        .DW    (CW)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // Index bound and item checks
    logic [IDX_W-1:0] limit;
    logic             write_ok;
    logic             query_ok;
    logic [LW-1:0]    leaf_first;
    logic [LW-1:0]    leaf_end;
    logic             in_accept;
    logic             out_free;
    logic             range_live;
    logic [CNT_W-1:0] odd_sum;
    logic [LW-1:0]    hi_dec;

    assign limit = (ecount_reg < IDX_W'(MAXCAP)) ? ecount_reg : IDX_W'(MAXCAP);
    assign write_ok = (in_first != '0) && (in_first <= limit);
    assign query_ok = (in_mode inside {MODE_EVEN, MODE_ODD}) && (in_first != '0)
                      && (in_last <= limit) && (in_first <= in_last);
    assign leaf_first = LW'(MAX_ELEMENTS) + LW'(in_first) - LW'(1);
    assign leaf_end   = LW'(MAX_ELEMENTS) + LW'(in_last);
    assign in_accept  = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign range_live = lo_reg < hi_reg;
    assign hi_dec     = hi_reg - LW'(1);
    assign odd_sum    = acc_reg
                        + ((pend_reg && take_a_reg) ? CNT_W'(mem_rdata_a) : '0)
                        + ((pend_reg && take_b_reg) ? CNT_W'(mem_rdata_b) : '0);

    // Ports
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = M_TDATA_W'(out_count_reg);
    assign m_tuser   = out_err_reg;

    // Next state, memory control and datapath
    always_comb
    begin
        state_next     = state_reg;
        ecount_next    = ecount_reg;
        clr_next       = clr_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        up_next        = up_reg;
        odd_mode_next  = odd_mode_reg;
        len_next       = len_reg;
        acc_next       = acc_reg;
        pend_next      = pend_reg;
        take_a_next    = take_a_reg;
        take_b_next    = take_b_reg;
        res_count_next = res_count_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_err_next   = out_err_reg;
        mem_we         = 1'b0;
        mem_waddr      = lo_reg[NW-1:0];
        mem_wdata      = '0;
        mem_raddr_a    = lo_reg[NW-1:0];
        mem_raddr_b    = hi_dec[NW-1:0];

        // Take config writes at any time
        if (cfg_valid)
        begin
            ecount_next = cfg_data;
        end

        // Drain the output register
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero one node per cycle
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + NW'(1);
                if (clr_reg == NW'(NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    up_next       = in_par;
                    odd_mode_next = (in_mode == MODE_ODD);
                    len_next      = in_last - in_first + CNT_W'(1);
                    res_count_next = '0;
                    res_err_next   = 1'b1;
                    if (in_mode == MODE_WRITE)
                    begin
                        if (write_ok)
                        begin
                            // Fetch the leaf to compare parity
                            mem_raddr_a = leaf_first[NW-1:0];
                            lo_next     = leaf_first;
                            state_next  = ST_UPD_LEAF;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                    else if (query_ok)
                    begin
                        lo_next    = leaf_first;
                        hi_next    = leaf_end;
                        acc_next   = '0;
                        pend_next  = 1'b0;
                        state_next = ST_QUERY;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_UPD_LEAF:
            begin
                if (mem_rdata_a[0] == up_reg)
                begin
                    // Parity unchanged: drop the item silently
                    state_next = ST_IDLE;
                end
                else
                begin
                    // Store new parity and fetch the parent
                    mem_we      = 1'b1;
                    mem_waddr   = lo_reg[NW-1:0];
                    mem_wdata   = CW'(up_reg);
                    mem_raddr_a = lo_reg[LW-1:1];
                    lo_next     = lo_reg >> 1;
                    state_next  = ST_UPD_WALK;
                end
            end

            ST_UPD_WALK:
            begin
                // Adjust this node's odd count and move toward the root
                mem_we      = 1'b1;
                mem_waddr   = lo_reg[NW-1:0];
                mem_wdata   = up_reg ? (mem_rdata_a + CW'(1)) : (mem_rdata_a - CW'(1));
                mem_raddr_a = lo_reg[LW-1:1];
                lo_next     = lo_reg >> 1;
                if (lo_reg == LW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_QUERY:
            begin
                // Fold in last level's nodes, fetch this level's boundary nodes
                acc_next    = odd_sum;
                pend_next   = range_live;
                take_a_next = range_live && lo_reg[0];
                take_b_next = range_live && hi_reg[0];
                lo_next     = (lo_reg + LW'(lo_reg[0])) >> 1;
                hi_next     = hi_reg >> 1;
                if (!range_live)
                begin
                    res_err_next   = 1'b0;
                    res_count_next = odd_mode_reg ? odd_sum : (len_reg - odd_sum);
                    state_next     = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // Hand the result to the output register once it is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = res_count_reg;
                    out_err_next   = res_err_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Register update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ecount_reg    <= ECOUNT_RESET;
            clr_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            up_reg        <= 1'b0;
            odd_mode_reg  <= 1'b0;
            len_reg       <= '0;
            acc_reg       <= '0;
            pend_reg      <= 1'b0;
            take_a_reg    <= 1'b0;
            take_b_reg    <= 1'b0;
            res_count_reg <= '0;
            res_err_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ecount_reg    <= ecount_next;
            clr_reg       <= clr_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            up_reg        <= up_next;
            odd_mode_reg  <= odd_mode_next;
            len_reg       <= len_next;
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            take_a_reg    <= take_a_next;
            take_b_reg    <= take_b_next;
            res_count_reg <= res_count_next;
            res_err_reg   <= res_err_next;
            out_valid_reg <= out_valid_next;
            out_count_reg <= out_count_next;
            out_err_reg   <= out_err_next;
        end
    end

endmodule

@@ test/tb_top.sv @@
// Self-checking bench for parity_count_segment_tree_core: random and directed items.
// It mirrors element parities and checks the even/odd counts. Depends on pct_pkg.
`timescale 1ns / 1ps

module tb_top
    import pct_pkg::*;
();

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] first_idx;
        logic [IDX_W-1:0] last_idx;
        logic [VAL_W-1:0] value;
    } tree_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             err;
    } count_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [IDX_W-1:0]     cfg_data = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;

    // Mirror of the block state
    bit               parity_mirror [MAX_ELEMENTS_DEF];
    logic [IDX_W-1:0] ecount_mirror = ECOUNT_RESET;

    tree_item_t    pending_items [$];
    count_result_t count_expect_q [$];
    tree_item_t    tx_item;
    count_result_t tx_result;
    count_result_t rx_want;
    bit            tx_busy = 1'b0;
    bit            calm = 1'b0;
    int            tx_hold = 0;
    int            rx_hold = 0;
    int            items_sent = 0;
    int            results_seen = 0;
    int            fault_count = 0;
    int            settings_used = 1;

    parity_count_segment_tree_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one item to the parity mirror; return 1 with the count it must produce
    function automatic bit predict_range_count(input tree_item_t it,
                                               output count_result_t res);
        int unsigned bound;
        int unsigned odd;
        int unsigned span;
        bound = (ecount_mirror < MAX_ELEMENTS_DEF) ? ecount_mirror : MAX_ELEMENTS_DEF;
        res = '0;
        if (it.mode == MODE_WRITE)
        begin
            if (it.first_idx == 0 || it.first_idx > bound)
            begin
                res.err = 1'b1;
                return 1'b1;
            end
            parity_mirror[it.first_idx - 1] = it.value[0];
            return 1'b0;
        end
        if (it.mode == MODE_BAD || it.first_idx == 0 || it.last_idx > bound ||
            it.first_idx > it.last_idx)
        begin
            res.err = 1'b1;
            return 1'b1;
        end
        odd = 0;
        for (int i = it.first_idx - 1; i < it.last_idx; i++)
            odd += parity_mirror[i];
        span = it.last_idx - it.first_idx + 1;
        if (it.mode != MODE_ODD)
            odd = span - odd;
        res.count = odd[CNT_W-1:0];
        return 1'b1;
    endfunction

    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, 4));
    endfunction

    task automatic flag_mismatch(input string what, input count_result_t want,
                                 input logic [CNT_W-1:0] got_count, input logic got_err);
        if (fault_count < 10)
            $display("%0t: %s: expected count %0d error %0b, got count %0d error %0b",
                     $realtime, what, want.count, want.err, got_count, got_err);
        fault_count++;
    endtask

    // Driver: hold each item until taken, then wait a random gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            tx_busy = 1'b0;
            tx_hold = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                items_sent++;
                if (predict_range_count(tx_item, tx_result))
                    count_expect_q.push_back(tx_result);
                tx_busy = 1'b0;
                tx_hold = draw_gap();
            end
            if (!tx_busy)
            begin
                if (tx_hold > 0)
                begin
                    tx_hold--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    tx_item = pending_items.pop_front();
                    tx_busy = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, tx_item.value, tx_item.last_idx, tx_item.first_idx};
                    s_tuser  <= tx_item.mode;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each result against the oldest expectation, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_hold = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (count_expect_q.size() == 0)
                    flag_mismatch("unexpected result", '0, m_tdata[CNT_W-1:0], m_tuser);
                else
                begin
                    rx_want = count_expect_q.pop_front();
                    if (m_tdata[CNT_W-1:0] !== rx_want.count || m_tuser !== rx_want.err)
                        flag_mismatch("result mismatch", rx_want, m_tdata[CNT_W-1:0],
                                      m_tuser);
                end
                rx_hold = draw_gap();
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic push_item(input logic [1:0] mode, input int unsigned first_idx,
                             input int unsigned last_idx, input logic [VAL_W-1:0] value);
        tree_item_t it;
        it.mode      = mode;
        it.first_idx = first_idx[IDX_W-1:0];
        it.last_idx  = last_idx[IDX_W-1:0];
        it.value     = value;
        pending_items.push_back(it);
    endtask

    // Pick an index, favoring both ends of the valid range
    function automatic int unsigned pick_index(input int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 1;
        if (r == 1)
            return span;
        return $urandom_range(1, span);
    endfunction

    function automatic tree_item_t random_item(input int unsigned span);
        tree_item_t  it;
        int unsigned r;
        int unsigned a;
        int unsigned b;
        r = $urandom_range(0, 99);
        it.value    = $urandom();
        it.last_idx = IDX_W'($urandom_range(0, 2047));
        if (r < 45)
        begin
            it.mode      = MODE_WRITE;
            it.first_idx = IDX_W'(pick_index(span));
        end
        else if (r < 90)
        begin
            it.mode = (r < 85) ? (($urandom_range(0, 1) != 0) ? MODE_ODD : MODE_EVEN)
                               : MODE_BAD;
            a = pick_index(span);
            if ($urandom_range(0, 1) != 0)
                b = $urandom_range(a, span);
            else
                b = (a + $urandom_range(0, 15) > span) ? span : a + $urandom_range(0, 15);
            it.first_idx = IDX_W'(a);
            it.last_idx  = IDX_W'(b);
        end
        else
        begin
            // noise: any mode, any index pattern
            it.mode      = 2'($urandom_range(0, 3));
            it.first_idx = IDX_W'($urandom_range(0, 2047));
            it.last_idx  = IDX_W'($urandom_range(0, 2047));
        end
        return it;
    endfunction

    // Wait until every item is taken and every result is back, then let the block settle
    task automatic wait_drained();
        while (pending_items.size() != 0 || tx_busy || count_expect_q.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic write_ecount(input logic [IDX_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ecount_mirror = value;
    endtask

    initial
    begin
        int unsigned phase_ecount [8];
        int          phase_items [8];
        int unsigned span;

        phase_ecount = '{1024, 1, 0, 2047, 64, 0, 1000, 1024};
        phase_items  = '{300, 150, 40, 300, 300, 300, 300, 300};
        phase_ecount[5] = $urandom_range(2, 1023);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full-range counts, both ends, bad indices, invalid mode
        push_item(MODE_ODD, 1, 1024, '0);
        push_item(MODE_EVEN, 1, 1024, '0);
        push_item(MODE_WRITE, 1, 0, 32'h0000_0001);
        push_item(MODE_WRITE, 1024, 2047, 32'hFFFF_FFFF);
        push_item(MODE_WRITE, 512, 0, 32'h8000_0000);
        push_item(MODE_WRITE, 1, 0, 32'h0000_0003);
        push_item(MODE_WRITE, 0, 0, 32'h0000_0001);
        push_item(MODE_WRITE, 1025, 0, 32'h0000_0001);
        push_item(MODE_WRITE, 2047, 2047, 32'hFFFF_FFFF);
        push_item(MODE_ODD, 1, 1024, '0);
        push_item(MODE_EVEN, 1, 1024, '0);
        push_item(MODE_EVEN, 1, 1, '0);
        push_item(MODE_ODD, 1024, 1024, '0);
        push_item(MODE_ODD, 0, 10, '0);
        push_item(MODE_EVEN, 1, 1025, '0);
        push_item(MODE_ODD, 20, 19, '0);
        push_item(MODE_BAD, 1, 1024, '0);
        push_item(MODE_BAD, 0, 0, '0);
        push_item(MODE_EVEN, 2047, 2047, 32'hFFFF_FFFF);
        push_item(MODE_WRITE, 1, 0, 32'h0000_0002);
        push_item(MODE_ODD, 1, 1024, '0);
        push_item(MODE_ODD, 2, 1023, '0);
        wait_drained();

        // Random phases, each under its own element_count
        for (int p = 0; p < 8; p++)
        begin
            write_ecount(phase_ecount[p][IDX_W-1:0]);
            settings_used++;
            calm = (p == 4 || p == 7);
            span = (phase_ecount[p] == 0) ? MAX_ELEMENTS_DEF :
                   (phase_ecount[p] < MAX_ELEMENTS_DEF) ? phase_ecount[p] : MAX_ELEMENTS_DEF;
            for (int n = 0; n < phase_items[p]; n++)
                pending_items.push_back(random_item(span));
            wait_drained();
        end

        // Anything still expected at the end is a missing result
        fault_count += count_expect_q.size();
        $display("Ran %0d items under %0d element_count settings; %0d results checked, %0d bad.",
                 items_sent, settings_used, results_seen, fault_count);
        if (fault_count == 0)
            $display("parity_count_segment_tree_core regression: pass");
        else
            $display("parity_count_segment_tree_core regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("parity_count_segment_tree_core regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
sv/pct_pkg.sv
sv/pct_node_ram.sv
sv/parity_count_segment_tree_core.sv
test/tb_top.sv
